FILE: hdl/sck_pkg.sv
// ----------------------------------------------------------------------------
// sck_pkg: shared types and constants of the sprite color key blitter
// Register map codes, field widths, key color thresholds and item types.
// ----------------------------------------------------------------------------
`default_nettype none

package sck_pkg;

  // bus and field widths
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned CTR_W    = 13;  // center coordinate registers
  localparam int unsigned DIMR_W   = 12;  // dimension registers
  localparam int unsigned PIX_W    = 16;
  localparam int unsigned ADDR_W   = 22;
  localparam int unsigned DEF_MAX_DIM = 2048;

  // register index, taken from paddr word address
  typedef enum logic [2:0] {
    REG_CENTER_X      = 3'd0,
    REG_CENTER_Y      = 3'd1,
    REG_SPRITE_WIDTH  = 3'd2,
    REG_SPRITE_HEIGHT = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5,
    REG_MODE          = 3'd6
  } reg_idx_e;

  // operating mode
  typedef enum logic {
    MODE_DRAW    = 1'b0,
    MODE_COLLIDE = 1'b1
  } mode_e;

  // reset values
  localparam logic [DIMR_W-1:0] RST_SPRITE_DIM = 12'd1;
  localparam logic [DIMR_W-1:0] RST_SCREEN_W   = 12'd1024;
  localparam logic [DIMR_W-1:0] RST_SCREEN_H   = 12'd768;

  // key color thresholds (RGB565)
  localparam logic [5:0] KEY_G_MIN = 6'h10;
  localparam logic [4:0] KEY_B_MAX = 5'h06;
  localparam logic [4:0] KEY_R_MAX = 5'h05;

  // destination colors that count as empty
  localparam logic [PIX_W-1:0] DEST_BLACK = 16'h0000;
  localparam logic [PIX_W-1:0] DEST_GREEN = 16'h07E0;

  // item fields carried from the position stage to the result stage
  typedef struct packed {
    logic [PIX_W-1:0] sprite_pixel;
    logic [PIX_W-1:0] dest_pixel;
    logic             start;
    logic             last;
  } item_t;

  // key color test
  function automatic logic is_key(input logic [PIX_W-1:0] p);
    logic [5:0] g;
    logic [4:0] b;
    logic [4:0] r;
    g = p[10:5];
    b = p[4:0];
    r = p[15:11];
    return (g >= KEY_G_MIN) && (b <= KEY_B_MAX) && (r <= KEY_R_MAX);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sprite_color_key_blitter_unit.sv
// An accepted item passes from the position register to the result register;
// out_ready_i low holds the result and back-pressures the position stage.
// Throughput: one item per cycle while out_ready_i is high, with a single
// multiply-add for the address in the result stage.
// Reset (rst_ni, asynchronous, active low) clears the pipeline, the pixel
// counters and the hit flag, and loads the register reset values.
// ----------------------------------------------------------------------------
// sprite_color_key_blitter_unit: color keyed sprite blitter with clipping
// Streams RGB565 sprite pixels into framebuffer writes or collision checks.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_color_key_blitter_unit #(
  parameter int unsigned MAX_DIM = sck_pkg::DEF_MAX_DIM
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sck_pkg::PADDR_W-1:0] paddr,
  input  wire logic [sck_pkg::DATA_W-1:0]  pwdata,
  output logic      [sck_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [sck_pkg::PIX_W-1:0]   sprite_pixel_i,
  input  wire logic [sck_pkg::PIX_W-1:0]   dest_pixel_i,
  input  wire logic                        start_req_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             write_enable_o,
  output logic [sck_pkg::ADDR_W-1:0]       address_o,
  output logic [sck_pkg::PIX_W-1:0]        pixel_o,
  output logic                             hit_o,
  output logic                             last_o
);
  import sck_pkg::*;

  localparam int unsigned DIM_W = $clog2(MAX_DIM) + 1;
  localparam int unsigned CNT_W = $clog2(MAX_DIM);
  localparam int unsigned POS_W = ((DIM_W > CTR_W) ? DIM_W : CTR_W) + 3;

  logic signed [CTR_W-1:0] center_x, center_y;
  logic [DIM_W-1:0]        sprite_w, sprite_h, screen_w, screen_h;
  mode_e                   mode;
  logic                    s1_valid, s1_ready;
  item_t                   s1_item;
  logic signed [POS_W-1:0] s1_col, s1_row;

  // configuration registers
  sck_cfg #(
    .MAX_DIM (MAX_DIM),
    .DIM_W   (DIM_W)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .center_x_o (center_x),
    .center_y_o (center_y),
    .sprite_w_o (sprite_w),
    .sprite_h_o (sprite_h),
    .screen_w_o (screen_w),
    .screen_h_o (screen_h),
    .mode_o     (mode)
  );

  // input register and position
  sck_pos #(
    .MAX_DIM (MAX_DIM),
    .DIM_W   (DIM_W),
    .CNT_W   (CNT_W),
    .POS_W   (POS_W)
  ) u_pos (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sprite_pixel_i (sprite_pixel_i),
    .dest_pixel_i   (dest_pixel_i),
    .start_req_i    (start_req_i),
    .center_x_i     (center_x),
    .center_y_i     (center_y),
    .sprite_w_i     (sprite_w),
    .sprite_h_i     (sprite_h),
    .s1_valid_o     (s1_valid),
    .s1_ready_i     (s1_ready),
    .s1_item_o      (s1_item),
    .s1_col_o       (s1_col),
    .s1_row_o       (s1_row)
  );

  // clipping, key test and result register
  sck_res #(
    .MAX_DIM (MAX_DIM),
    .DIM_W   (DIM_W),
    .CNT_W   (CNT_W),
    .POS_W   (POS_W)
  ) u_res (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s1_valid_i     (s1_valid),
    .s1_ready_o     (s1_ready),
    .s1_item_i      (s1_item),
    .s1_col_i       (s1_col),
    .s1_row_i       (s1_row),
    .screen_w_i     (screen_w),
    .screen_h_i     (screen_h),
    .mode_i         (mode),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .write_enable_o (write_enable_o),
    .address_o      (address_o),
    .pixel_o        (pixel_o),
    .hit_o          (hit_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

FILE: hdl/sck_cfg.sv
// ----------------------------------------------------------------------------
// sck_cfg: configuration registers
// APB-style register file with effective (clamped) sprite and screen sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module sck_cfg #(
  parameter int unsigned MAX_DIM = sck_pkg::DEF_MAX_DIM,
  parameter int unsigned DIM_W   = $clog2(MAX_DIM) + 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [sck_pkg::PADDR_W-1:0] paddr,
  input  wire logic [sck_pkg::DATA_W-1:0]  pwdata,
  output logic      [sck_pkg::DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic signed [sck_pkg::CTR_W-1:0] center_x_o,
  output logic signed [sck_pkg::CTR_W-1:0] center_y_o,
  output logic      [DIM_W-1:0]           sprite_w_o,
  output logic      [DIM_W-1:0]           sprite_h_o,
  output logic      [DIM_W-1:0]           screen_w_o,
  output logic      [DIM_W-1:0]           screen_h_o,
  output sck_pkg::mode_e                  mode_o
);
  import sck_pkg::*;

  localparam int unsigned CMP_W = (DIM_W > DIMR_W) ? DIM_W : DIMR_W;

  logic [CTR_W-1:0]  center_x_q;
  logic [CTR_W-1:0]  center_y_q;
  logic [DIMR_W-1:0] sprite_w_q;
  logic [DIMR_W-1:0] sprite_h_q;
  logic [DIMR_W-1:0] screen_w_q;
  logic [DIMR_W-1:0] screen_h_q;
  mode_e             mode_q;
  logic              wr_en;
  reg_idx_e          idx;

  // a zero size takes effect as one, oversize is clamped to MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIMR_W-1:0] d);
    logic [CMP_W-1:0] dw;
    dw = CMP_W'(d);
    if (d == '0) begin
      return DIM_W'(1);
    end else if (dw > CMP_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(dw);
  endfunction

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      sprite_w_q <= RST_SPRITE_DIM;
      sprite_h_q <= RST_SPRITE_DIM;
      screen_w_q <= RST_SCREEN_W;
      screen_h_q <= RST_SCREEN_H;
      mode_q     <= MODE_DRAW;
    end else if (wr_en) begin
      case (idx)
        REG_CENTER_X:      center_x_q <= pwdata[CTR_W-1:0];
        REG_CENTER_Y:      center_y_q <= pwdata[CTR_W-1:0];
        REG_SPRITE_WIDTH:  sprite_w_q <= pwdata[DIMR_W-1:0];
        REG_SPRITE_HEIGHT: sprite_h_q <= pwdata[DIMR_W-1:0];
        REG_SCREEN_WIDTH:  screen_w_q <= pwdata[DIMR_W-1:0];
        REG_SCREEN_HEIGHT: screen_h_q <= pwdata[DIMR_W-1:0];
        REG_MODE:          mode_q     <= mode_e'(pwdata[0]);
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_CENTER_X:      prdata = DATA_W'(center_x_q);
      REG_CENTER_Y:      prdata = DATA_W'(center_y_q);
      REG_SPRITE_WIDTH:  prdata = DATA_W'(sprite_w_q);
      REG_SPRITE_HEIGHT: prdata = DATA_W'(sprite_h_q);
      REG_SCREEN_WIDTH:  prdata = DATA_W'(screen_w_q);
      REG_SCREEN_HEIGHT: prdata = DATA_W'(screen_h_q);
      REG_MODE:          prdata = DATA_W'(mode_q);
      default:           prdata = '0;
    endcase
  end

  assign center_x_o = $signed(center_x_q);
  assign center_y_o = $signed(center_y_q);
  assign sprite_w_o = eff_dim(sprite_w_q);
  assign sprite_h_o = eff_dim(sprite_h_q);
  assign screen_w_o = eff_dim(screen_w_q);
  assign screen_h_o = eff_dim(screen_h_q);
  assign mode_o     = mode_q;

endmodule

`default_nettype wire

FILE: hdl/sck_pos.sv
// ----------------------------------------------------------------------------
// sck_pos: input register and pixel position stage
// Tracks column and row counters and registers the screen position of each item.
// ----------------------------------------------------------------------------
`default_nettype none

module sck_pos #(
  parameter int unsigned MAX_DIM = sck_pkg::DEF_MAX_DIM,
  parameter int unsigned DIM_W   = $clog2(MAX_DIM) + 1,
  parameter int unsigned CNT_W   = $clog2(MAX_DIM),
  parameter int unsigned POS_W   = ((DIM_W > sck_pkg::CTR_W) ? DIM_W : sck_pkg::CTR_W) + 3
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [sck_pkg::PIX_W-1:0]   sprite_pixel_i,
  input  wire logic [sck_pkg::PIX_W-1:0]   dest_pixel_i,
  input  wire logic                        start_req_i,
  input  wire logic signed [sck_pkg::CTR_W-1:0] center_x_i,
  input  wire logic signed [sck_pkg::CTR_W-1:0] center_y_i,
  input  wire logic [DIM_W-1:0]            sprite_w_i,
  input  wire logic [DIM_W-1:0]            sprite_h_i,
  output logic                             s1_valid_o,
  input  wire logic                        s1_ready_i,
  output sck_pkg::item_t                   s1_item_o,
  output logic signed [POS_W-1:0]          s1_col_o,
  output logic signed [POS_W-1:0]          s1_row_o
);
  import sck_pkg::*;

  logic                    accept;
  logic                    s1_valid_q, s1_valid_d;
  logic [CNT_W-1:0]        col_cnt_q, col_cnt_d;
  logic [CNT_W-1:0]        row_cnt_q, row_cnt_d;
  logic [CNT_W-1:0]        col_eff, row_eff;
  logic [DIM_W-1:0]        col_inc, row_inc;
  logic [DIM_W-1:0]        h_up;
  logic                    row_end, last;
  logic signed [POS_W-1:0] col_d, row_d;
  item_t                   item_q, item_d;
  logic signed [POS_W-1:0] col_q, row_q;

  // handshake: take a new item whenever the register is free or draining
  assign in_ready_o = !s1_valid_q || s1_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign s1_valid_d = accept || (s1_valid_q && !s1_ready_i);

  // counters restart on a start request
  assign col_eff = start_req_i ? '0 : col_cnt_q;
  assign row_eff = start_req_i ? '0 : row_cnt_q;
  assign col_inc = DIM_W'(col_eff) + DIM_W'(1);
  assign row_inc = DIM_W'(row_eff) + DIM_W'(1);
  assign row_end = col_inc >= sprite_w_i;
  assign last    = row_end && (row_inc >= sprite_h_i);

  // next counter values
  always_comb begin
    if (last) begin
      col_cnt_d = '0;
      row_cnt_d = '0;
    end else if (row_end) begin
      col_cnt_d = '0;
      row_cnt_d = row_inc[CNT_W-1:0];
    end else begin
      col_cnt_d = col_inc[CNT_W-1:0];
      row_cnt_d = row_eff;
    end
  end

  // screen position; rows are stored bottom-up
  assign h_up  = sprite_h_i - (sprite_h_i >> 1);
  assign col_d = POS_W'(center_x_i) - $signed(POS_W'(sprite_w_i >> 1))
               + $signed(POS_W'(col_eff));
  assign row_d = POS_W'(center_y_i) + $signed(POS_W'(h_up)) - POS_W'(1)
               - $signed(POS_W'(row_eff));

  always_comb begin
    item_d.sprite_pixel = sprite_pixel_i;
    item_d.dest_pixel   = dest_pixel_i;
    item_d.start        = start_req_i;
    item_d.last         = last;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      col_cnt_q  <= '0;
      row_cnt_q  <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        col_cnt_q <= col_cnt_d;
        row_cnt_q <= row_cnt_d;
      end
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_item_o  = item_q;
  assign s1_col_o   = col_q;
  assign s1_row_o   = row_q;

endmodule

`default_nettype wire

FILE: hdl/sck_res.sv
// ----------------------------------------------------------------------------
// sck_res: clipping, key test and result register
// Forms the framebuffer address, write enable and sticky collision flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sck_res #(
  parameter int unsigned MAX_DIM = sck_pkg::DEF_MAX_DIM,
  parameter int unsigned DIM_W   = $clog2(MAX_DIM) + 1,
  parameter int unsigned CNT_W   = $clog2(MAX_DIM),
  parameter int unsigned POS_W   = ((DIM_W > sck_pkg::CTR_W) ? DIM_W : sck_pkg::CTR_W) + 3
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s1_valid_i,
  output logic                            s1_ready_o,
  input  wire sck_pkg::item_t             s1_item_i,
  input  wire logic signed [POS_W-1:0]    s1_col_i,
  input  wire logic signed [POS_W-1:0]    s1_row_i,
  input  wire logic [DIM_W-1:0]           screen_w_i,
  input  wire logic [DIM_W-1:0]           screen_h_i,
  input  wire sck_pkg::mode_e             mode_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            write_enable_o,
  output logic [sck_pkg::ADDR_W-1:0]      address_o,
  output logic [sck_pkg::PIX_W-1:0]       pixel_o,
  output logic                            hit_o,
  output logic                            last_o
);
  import sck_pkg::*;

  localparam int unsigned PROD_W = CNT_W + DIM_W + 1;
  localparam int unsigned EXT_W  = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;

  logic              adv;
  logic              out_valid_q, out_valid_d;
  logic              visible, draw, collide;
  logic [EXT_W-1:0]  lin_addr;
  logic              we_q, we_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [PIX_W-1:0]  pixel_q;
  logic              hit_q, hit_d;
  logic              last_q;

  // output register handshake
  assign s1_ready_o  = !out_valid_q || out_ready_i;
  assign adv         = s1_valid_i && s1_ready_o;
  assign out_valid_d = adv || (out_valid_q && !out_ready_i);

  // clip against the screen
  assign visible = !s1_col_i[POS_W-1] && !s1_row_i[POS_W-1]
                && (s1_col_i[POS_W-2:0] < (POS_W-1)'(screen_w_i))
                && (s1_row_i[POS_W-2:0] < (POS_W-1)'(screen_h_i));
  assign draw    = visible && !is_key(s1_item_i.sprite_pixel);

  // row-major framebuffer address
  assign lin_addr = EXT_W'(s1_row_i[CNT_W-1:0]) * EXT_W'(screen_w_i)
                  + EXT_W'(s1_col_i[CNT_W-1:0]);
  assign addr_d   = visible ? lin_addr[ADDR_W-1:0] : '0;
  assign we_d     = draw && (mode_i == MODE_DRAW);

  // sticky collision flag, cleared at the start of a pass
  assign collide = draw && (mode_i == MODE_COLLIDE)
                && (s1_item_i.dest_pixel != DEST_BLACK)
                && (s1_item_i.dest_pixel != DEST_GREEN);
  assign hit_d   = (hit_q && !s1_item_i.start) || collide;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (adv) begin
        hit_q <= hit_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      we_q    <= we_d;
      addr_q  <= addr_d;
      pixel_q <= s1_item_i.sprite_pixel;
      last_q  <= s1_item_i.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_enable_o = we_q;
  assign address_o      = addr_q;
  assign pixel_o        = pixel_q;
  assign hit_o          = hit_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire
